// ===== rtl/teq_pkg.sv =====
// shared types, constants and codes of the timed event queue
// no dependencies
package teq_pkg;

  localparam int SLOTS       = 16;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int ID_W        = 4;
  localparam int IDS         = 1 << ID_W;
  localparam int STAMP_W     = 64;
  localparam int SLACK_W     = 16;
  localparam int SLACK_RESET = 16;

  typedef enum logic [1:0] {
    REQ_SCHED  = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_POP    = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_DUP    = 3'd2,
    ST_ABSENT = 3'd3,
    ST_PAST   = 3'd4,
    ST_EMPTY  = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [ID_W-1:0]    event_id;
    logic [STAMP_W-1:0] deadline;
    logic [STAMP_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               popped_valid;
    logic [ID_W-1:0]    popped_id;
    logic [STAMP_W-1:0] popped_deadline;
    logic               head_valid;
    logic [ID_W-1:0]    head_id;
    logic [STAMP_W-1:0] target_stamp;
    logic [CNT_W-1:0]   queued_count;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] deadline;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_CUR  = 2'd1,
    RD_PREV = 2'd2,
    RD_NEXT = 2'd3
  } rd_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_ZERO = 3'd1,
    IDX_OCC  = 3'd2,
    IDX_INC  = 3'd3,
    IDX_DEC  = 3'd4
  } idx_op_t;

  typedef enum logic {
    WR_NEW  = 1'b0,
    WR_MOVE = 1'b1
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    ins_commit;
    logic    rm_mark;
    logic    rm_commit;
    logic    pop_mark;
    logic    set_status;
    status_t status_code;
    logic    out_load;
  } teq_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       id_queued;
    logic       dl_past;
    logic       full;
    logic       occ_zero;
    logic       idx_zero;
    logic       idx_last;
    logic       rd_before_dl;
    logic       rd_past;
    logic       rd_id_hit;
    logic       out_free;
  } teq_stat_t;

endpackage

// ===== rtl/teq_req_if.sv =====
// request channel: valid/ready handshake with a request payload
// depends on teq_pkg
interface teq_req_if;
  import teq_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/teq_rsp_if.sv =====
// response channel: valid/ready handshake with a result payload
// depends on teq_pkg
interface teq_rsp_if;
  import teq_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/teq_ram.sv =====
// generic ram: one write port, one read port with registered read data
// no dependencies
module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/teq_ctrl.sv =====
// controller of the timed event queue: sequences checks, slot walks and result load
// depends on teq_pkg
module teq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  teq_pkg::teq_stat_t stat,
  output teq_pkg::teq_cmd_t  cmd
);
  import teq_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE       = 12'b000000000001,
    S_CHECK      = 12'b000000000010,
    S_INS_STEP   = 12'b000000000100,
    S_INS_CMP    = 12'b000000001000,
    S_FIND_RD    = 12'b000000010000,
    S_FIND_CMP   = 12'b000000100000,
    S_POP_RD     = 12'b000001000000,
    S_POP_CMP    = 12'b000010000000,
    S_SHIFT_STEP = 12'b000100000000,
    S_SHIFT_WR   = 12'b001000000000,
    S_HEAD_RD    = 12'b010000000000,
    S_HEAD_CAP   = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_HEAD_RD;
        case (stat.req_type)
          REQ_SCHED: begin
            if (stat.id_queued) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_DUP;
            end else if (stat.dl_past) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_PAST;
            end else if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.idx_op = IDX_OCC;
              state_next = S_INS_STEP;
            end
          end
          REQ_CANCEL: begin
            if (!stat.id_queued) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_ABSENT;
            end else begin
              cmd.idx_op = IDX_ZERO;
              state_next = S_FIND_RD;
            end
          end
          REQ_POP: begin
            if (stat.occ_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
            end else begin
              cmd.idx_op = IDX_ZERO;
              state_next = S_POP_RD;
            end
          end
          default: begin
            state_next = S_HEAD_RD;
          end
        endcase
      end
      S_INS_STEP: begin
        if (stat.idx_zero) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = WR_NEW;
          cmd.ins_commit = 1'b1;
          state_next     = S_HEAD_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.rd_before_dl) begin
          cmd.wr_sel     = WR_NEW;
          cmd.ins_commit = 1'b1;
          state_next     = S_HEAD_RD;
        end else begin
          cmd.wr_sel = WR_MOVE;
          cmd.idx_op = IDX_DEC;
          state_next = S_INS_STEP;
        end
      end
      S_FIND_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CUR;
        state_next = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (stat.rd_id_hit) begin
          if (stat.rd_past) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_PAST;
            state_next      = S_HEAD_RD;
          end else begin
            cmd.rm_mark = 1'b1;
            state_next  = S_SHIFT_STEP;
          end
        end else if (stat.idx_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_ABSENT;
          state_next      = S_HEAD_RD;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_FIND_RD;
        end
      end
      S_POP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HEAD;
        state_next = S_POP_CMP;
      end
      S_POP_CMP: begin
        if (stat.rd_past) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_PAST;
          state_next      = S_HEAD_RD;
        end else begin
          cmd.rm_mark  = 1'b1;
          cmd.pop_mark = 1'b1;
          state_next   = S_SHIFT_STEP;
        end
      end
      S_SHIFT_STEP: begin
        if (stat.idx_last) begin
          cmd.rm_commit = 1'b1;
          state_next    = S_HEAD_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_MOVE;
        cmd.idx_op = IDX_INC;
        state_next = S_SHIFT_STEP;
      end
      S_HEAD_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HEAD;
        state_next = S_HEAD_CAP;
      end
      S_HEAD_CAP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/teq_dp.sv =====
// datapath of the timed event queue: slot table, occupancy, id mask, result register
// depends on teq_pkg and teq_ram
module teq_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  teq_pkg::req_t                  req_data,
  input  logic                           cfg_we,
  input  logic [teq_pkg::SLACK_W-1:0]    cfg_data,
  input  teq_pkg::teq_cmd_t              cmd,
  output teq_pkg::teq_stat_t             stat,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output teq_pkg::rsp_t                  rsp_data
);
  import teq_pkg::*;

  req_t               req_q;
  logic [CNT_W-1:0]   occ;
  logic [IDS-1:0]     mask;
  logic [CNT_W-1:0]   idx;
  logic [SLACK_W-1:0] slack;
  status_t            st;
  logic [ID_W-1:0]    rm_id;
  logic               pop_valid;
  logic [ID_W-1:0]    pop_id;
  logic [STAMP_W-1:0] pop_dl;
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic [ENTRY_W-1:0] rdata;
  logic [CNT_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   idx_plus;
  rsp_t               rsp_next;

  assign rd_entry = entry_t'(rdata);
  assign idx_plus = idx + CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD: rd_idx = '0;
      RD_CUR:  rd_idx = idx;
      RD_PREV: rd_idx = idx - CNT_W'(1);
      RD_NEXT: rd_idx = idx_plus;
      default: rd_idx = '0;
    endcase
  end

  assign wr_entry = (cmd.wr_sel == WR_NEW) ? entry_t'({req_q.event_id, req_q.deadline})
                                           : rd_entry;

  teq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (idx[IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (cmd.rd_en),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slack <= SLACK_W'(SLACK_RESET);
    end else if (cfg_we) begin
      slack <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_data;
    end
    if (cmd.rm_mark) begin
      rm_id <= rd_entry.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      mask      <= '0;
      idx       <= '0;
      st        <= ST_OK;
      pop_valid <= 1'b0;
      pop_id    <= '0;
      pop_dl    <= '0;
    end else begin
      if (cmd.ins_commit) begin
        occ                   <= occ + CNT_W'(1);
        mask[req_q.event_id]  <= 1'b1;
      end else if (cmd.rm_commit) begin
        occ         <= occ - CNT_W'(1);
        mask[rm_id] <= 1'b0;
      end
      case (cmd.idx_op)
        IDX_ZERO: idx <= '0;
        IDX_OCC:  idx <= occ;
        IDX_INC:  idx <= idx_plus;
        IDX_DEC:  idx <= idx - CNT_W'(1);
        default:  idx <= idx;
      endcase
      if (cmd.load) begin
        st        <= ST_OK;
        pop_valid <= 1'b0;
        pop_id    <= '0;
        pop_dl    <= '0;
      end else begin
        if (cmd.set_status) begin
          st <= cmd.status_code;
        end
        if (cmd.pop_mark) begin
          pop_valid <= 1'b1;
          pop_id    <= rd_entry.id;
          pop_dl    <= rd_entry.deadline;
        end
      end
    end
  end

  always_comb begin
    rsp_next.status          = st;
    rsp_next.popped_valid    = pop_valid;
    rsp_next.popped_id       = pop_id;
    rsp_next.popped_deadline = pop_dl;
    rsp_next.head_valid      = (occ != '0);
    rsp_next.head_id         = (occ != '0) ? rd_entry.id : '0;
    rsp_next.target_stamp    = (occ != '0) ? rd_entry.deadline
                                           : req_q.now + STAMP_W'(slack);
    rsp_next.queued_count    = occ;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_data <= rsp_next;
    end
  end

  always_comb begin
    stat.req_type     = req_q.req_type;
    stat.id_queued    = mask[req_q.event_id];
    stat.dl_past      = (req_q.deadline < req_q.now);
    stat.full         = (occ == CNT_W'(SLOTS));
    stat.occ_zero     = (occ == '0);
    stat.idx_zero     = (idx == '0);
    stat.idx_last     = (idx_plus >= occ);
    stat.rd_before_dl = (rd_entry.deadline < req_q.deadline);
    stat.rd_past      = (rd_entry.deadline < req_q.now);
    stat.rd_id_hit    = (rd_entry.id == req_q.event_id);
    stat.out_free     = !rsp_valid || rsp_ready;
  end

  a_mask_matches_occ: assert property (@(posedge clk) disable iff (rst)
    $countones(mask) == int'(occ))
    else $error("queued id mask and occupancy disagree");

  a_occ_bounded: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(SLOTS))
    else $error("occupancy above slot count");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("result overwritten before transfer");

  a_pop_is_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && pop_valid |=> rsp_data.status == ST_OK && rsp_data.head_valid ==
      ($past(occ) != '0))
    else $error("popped result with bad status or head");

endmodule

// ===== rtl/timed_event_queue_core.sv =====
// top level of the timed event queue: controller, datapath and channel hookup
// depends on teq_pkg, teq_req_if, teq_rsp_if, teq_ctrl, teq_dp
//
// channel   dir  handshake     payload
// req       in   valid/ready   req_type, event_id, deadline, now
// rsp       out  valid/ready   status, popped, head, target_stamp, queued_count
// cfg       in   cfg_we        cfg_data = empty_slack
//
// one request at a time; a request rejected at the check only reads the head, while
// a cancel may walk and close the whole table: the slot table has one read and one
// write port, and each slot visited takes a read and then a compare or a write
// rst is synchronous and empties the queue; slot contents are not cleared
// a result waiting on rsp holds the next result back, not the next transfer on req
module timed_event_queue_core (
  input  logic                        clk,
  input  logic                        rst,
  teq_req_if.sink                     req,
  teq_rsp_if.source                   rsp,
  input  logic                        cfg_we,
  input  logic [teq_pkg::SLACK_W-1:0] cfg_data
);
  import teq_pkg::*;

  teq_cmd_t  cmd;
  teq_stat_t stat;

  teq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  teq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req.data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

endmodule
